// ===== rtl/mbe_pkg.sv =====
package mbe_pkg;

    // Fixed point format of c and z: signed, DataWidth bits, FracBits fraction bits.
    localparam int DataWidth = 32;
    localparam int FracBits  = 26;

    // Iteration counter and limit register.
    localparam int                    IterWidth    = 12;
    localparam logic [IterWidth-1:0]  MaxIterReset = IterWidth'(1000);

    // Internal escaped-point counter and the width of the reported count.
    localparam int CountWidth    = 20;
    localparam int EscCountWidth = 20;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic ready;     // point channel may take a transfer
        logic load;      // a point is taken: load c and z, clear the counter
        logic mul;       // register the three products of the current z
        logic step;      // write the updated z and advance the counter
        logic conclude;  // latch the escape decision for this point
        logic emit;      // write the result into the output register
    } mbe_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic point_valid;  // a point is offered
        logic escape;       // the current z lies outside the radius-2 circle
        logic at_limit;     // the iteration count has reached the limit
        logic out_free;     // the output register can take a new result
    } mbe_status_t;

endpackage

// ===== rtl/mbe_point_if.sv =====
interface mbe_point_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [mbe_pkg::DataWidth-1:0] c_real;
    logic signed [mbe_pkg::DataWidth-1:0] c_imag;
    logic                                 clear_count;

    modport source (output valid, output c_real, output c_imag, output clear_count,
                    input ready);
    modport sink   (input valid, input c_real, input c_imag, input clear_count,
                    output ready);
endinterface

// ===== rtl/mbe_result_if.sv =====
interface mbe_result_if;
    logic                               valid;
    logic                               ready;
    logic                               escaped;
    logic [mbe_pkg::IterWidth-1:0]      iterations;
    logic [mbe_pkg::EscCountWidth-1:0]  escaped_count;

    modport source (output valid, output escaped, output iterations, output escaped_count,
                    input ready);
    modport sink   (input valid, input escaped, input iterations, input escaped_count,
                    output ready);
endinterface

// ===== rtl/mandelbrot_escape_test.sv =====
// Mandelbrot escape-time test. Each transfer on the points channel carries one
// complex point c (signed Q6.26) and a clear_count flag; each transfer on the
// results channel returns whether the point escaped, how many iterations ran
// (the escape iteration plus one, or max_iterations when the point stayed
// inside), and the running count of escaped points, which saturates at its
// maximum and is cleared by a point that sets clear_count. Each iteration
// first registers the three 32 x 32 products of z and then tests the
// magnitude and forms the new z, until the point escapes or the limit is
// reached. One point is worked on at a time; the output register holds a
// finished result while the next point is taken and worked on. max_iterations
// (reset value 1000) is written through cfg_we/cfg_wdata and should only
// change while no point is in flight; a limit of zero runs no iteration and
// reports the point as inside.
module mandelbrot_escape_test (
    input  logic                           clk,
    input  logic                           rst_n,
    mbe_point_if.sink                      points,
    mbe_result_if.source                   results,
    input  logic                           cfg_we,
    input  logic [mbe_pkg::IterWidth-1:0]  cfg_wdata
);

    // Command and status buses between the sequencer and the arithmetic.
    mbe_pkg::mbe_cmd_t    cmd;
    mbe_pkg::mbe_status_t status;

    // The controller steps through load, multiply, check and output.
    mbe_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    // The datapath holds the limit register, z, the products, the iteration
    // counter, the escaped-point counter and the output register.
    mbe_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .points    (points),
        .results   (results),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

// ===== rtl/mbe_ctrl.sv =====
module mbe_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  mbe_pkg::mbe_status_t status,
    output mbe_pkg::mbe_cmd_t    cmd
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_MUL   = 4'b0010,
        S_CHECK = 4'b0100,
        S_DONE  = 4'b1000
    } mbe_state_t;

    mbe_state_t state_reg;
    mbe_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                cmd.ready = 1'b1;
                if (status.point_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                // Escape is tested before the limit, so an escape on the last
                // allowed update still counts as an escape.
                if (status.escape || status.at_limit)
                begin
                    cmd.conclude = 1'b1;
                    state_next   = S_DONE;
                end
                else
                begin
                    cmd.step   = 1'b1;
                    state_next = S_MUL;
                end
            end
            S_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // A result is never written over one that is still waiting.
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> status.out_free)
        else $error("result written while output register is occupied");

    // Only one point is in flight: no new point is taken after a load until it is emitted.
    a_single_point: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> !cmd.ready)
        else $error("point channel ready right after a load");

endmodule

// ===== rtl/mbe_datapath.sv =====
module mbe_datapath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    mbe_point_if.sink                            points,
    mbe_result_if.source                         results,
    input  logic                                 cfg_we,
    input  logic [mbe_pkg::IterWidth-1:0]        cfg_wdata,
    input  mbe_pkg::mbe_cmd_t                    cmd,
    output mbe_pkg::mbe_status_t                 status
);

    localparam int DW  = mbe_pkg::DataWidth;
    localparam int PW  = 2 * DW;
    localparam int SW  = PW + 1;
    localparam int IW  = mbe_pkg::IterWidth;
    localparam int CW  = mbe_pkg::CountWidth;
    localparam logic [PW-1:0] MagLimit = PW'(4) << (2 * mbe_pkg::FracBits);
    localparam logic [CW-1:0] CountMax = {CW{1'b1}};

    // Clamp a wide signed sum to the signed data range.
    function automatic logic signed [DW-1:0] sat_data(input logic signed [SW-1:0] v);
        logic signed [DW-1:0] r;
        if (v[SW-1:DW-1] == {(SW-DW+1){v[SW-1]}})
        begin
            r = v[DW-1:0];
        end
        else if (v[SW-1])
        begin
            r = {1'b1, {(DW-1){1'b0}}};
        end
        else
        begin
            r = {1'b0, {(DW-1){1'b1}}};
        end
        return r;
    endfunction

    logic [IW-1:0]          max_iter_reg;
    logic signed [DW-1:0]   c_real_reg;
    logic signed [DW-1:0]   c_imag_reg;
    logic signed [DW-1:0]   z_real_reg;
    logic signed [DW-1:0]   z_imag_reg;
    logic signed [PW-1:0]   rr_reg;
    logic signed [PW-1:0]   ii_reg;
    logic signed [PW-1:0]   ri_reg;
    logic [IW-1:0]          iter_reg;
    logic                   first_reg;
    logic                   esc_reg;
    logic [CW-1:0]          count_reg;
    logic [CW-1:0]          count_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic                   out_escaped_reg;
    logic [IW-1:0]          out_iter_reg;
    logic [CW-1:0]          out_count_reg;

    logic signed [PW-1:0]   rr_prod;
    logic signed [PW-1:0]   ii_prod;
    logic signed [PW-1:0]   ri_prod;
    logic signed [PW-1:0]   diff;
    logic signed [PW-1:0]   diff_sh;
    logic signed [PW-1:0]   ri_sh;
    logic signed [SW-1:0]   nr_sum;
    logic signed [SW-1:0]   ni_sum;
    logic signed [DW-1:0]   z_real_new;
    logic signed [DW-1:0]   z_imag_new;
    logic [PW-1:0]          mag;
    logic                   escape;
    logic [CW-1:0]          count_base;

    assign rr_prod = z_real_reg * z_real_reg;
    assign ii_prod = z_imag_reg * z_imag_reg;
    assign ri_prod = z_real_reg * z_imag_reg;

    // z' = z*z + c; the imaginary part carries the factor two in its shift.
    assign diff       = rr_reg - ii_reg;
    assign diff_sh    = diff >>> mbe_pkg::FracBits;
    assign ri_sh      = ri_reg >>> (mbe_pkg::FracBits - 1);
    assign nr_sum     = SW'(diff_sh) + SW'(c_real_reg);
    assign ni_sum     = SW'(ri_sh) + SW'(c_imag_reg);
    assign z_real_new = sat_data(nr_sum);
    assign z_imag_new = sat_data(ni_sum);

    // Both squares are non-negative and at most 2^62, so the sum cannot wrap.
    assign mag    = rr_reg + ii_reg;
    assign escape = !first_reg && (mag > MagLimit);

    assign status.point_valid = points.valid;
    assign status.escape      = escape;
    assign status.at_limit    = (iter_reg == max_iter_reg);
    assign status.out_free    = !out_valid_reg || results.ready;

    assign points.ready = cmd.ready;

    assign count_base = (cmd.load && points.clear_count) ? '0 : count_reg;
    assign count_next = (cmd.emit && esc_reg && (count_reg != CountMax))
                        ? count_reg + CW'(1) : count_base;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_iter_reg  <= mbe_pkg::MaxIterReset;
            iter_reg      <= '0;
            first_reg     <= 1'b1;
            esc_reg       <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                max_iter_reg <= cfg_wdata;
            end
            if (cmd.load)
            begin
                iter_reg  <= '0;
                first_reg <= 1'b1;
            end
            else if (cmd.step)
            begin
                iter_reg  <= iter_reg + IW'(1);
                first_reg <= 1'b0;
            end
            if (cmd.conclude)
            begin
                esc_reg <= escape;
            end
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            c_real_reg <= points.c_real;
            c_imag_reg <= points.c_imag;
            z_real_reg <= points.c_real;
            z_imag_reg <= points.c_imag;
        end
        else if (cmd.step)
        begin
            z_real_reg <= z_real_new;
            z_imag_reg <= z_imag_new;
        end
        if (cmd.mul)
        begin
            rr_reg <= rr_prod;
            ii_reg <= ii_prod;
            ri_reg <= ri_prod;
        end
        if (cmd.emit)
        begin
            out_escaped_reg <= esc_reg;
            out_iter_reg    <= iter_reg;
            out_count_reg   <= count_next;
        end
    end

    assign results.valid         = out_valid_reg;
    assign results.escaped       = out_escaped_reg;
    assign results.iterations    = out_iter_reg;
    assign results.escaped_count = mbe_pkg::EscCountWidth'(out_count_reg);

    // A full counter stays full unless a point asks for a clear.
    a_count_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == CountMax && !(cmd.load && points.clear_count)) |=> count_reg == CountMax)
        else $error("escaped-point count left its saturated value");

    // An escape can only follow at least one update.
    a_escape_after_update: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && esc_reg) |-> iter_reg != '0)
        else $error("escape reported with no iteration run");

endmodule
